FILE: rtl/core/scic_pkg.sv
`default_nettype none
package scic_pkg;

  localparam int MAX_ANCHORS = 64;
  localparam int AIDX_W      = $clog2(MAX_ANCHORS);
  localparam int CNT_W       = 7;
  localparam int TIME_W      = 32;
  localparam int SURV_W      = 17;
  localparam int METHOD_W    = 2;
  localparam int REGION_W    = 2;
  localparam int FRAC_W      = 16;
  localparam int EXP_INT_W   = 4;
  localparam int LOG_W       = 21;
  localparam int SQ_W        = SURV_W + 1;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 21;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int NUM_W       = MUL_P_W;
  localparam int DEN_W       = TIME_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int E_W         = NUM_W + 2;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [SURV_W-1:0] ONE_Q16 = SURV_W'(1) << FRAC_W;

  // round(2^(2^-(i+1)) * 2^16)
  localparam logic [SURV_W-1:0] EXP_STEPS [FRAC_W] = '{
    17'd92682, 17'd77936, 17'd71468, 17'd68438, 17'd66971, 17'd66250, 17'd65892, 17'd65714,
    17'd65625, 17'd65580, 17'd65558, 17'd65547, 17'd65542, 17'd65539, 17'd65537, 17'd65537
  };

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [METHOD_W-1:0] {
    MTH_SURV = 2'd0,
    MTH_DENS = 2'd1,
    MTH_HAZ  = 2'd2
  } method_t;

  typedef enum logic [REGION_W-1:0] {
    RG_ZERO   = 2'd0,
    RG_EXACT  = 2'd1,
    RG_INTERP = 2'd2,
    RG_EXTRAP = 2'd3
  } region_t;

  typedef enum logic {
    REG_METHOD = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CP_VALUE,
    CP_LIN,
    CP_HAZ
  } calc_path_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ROUTE,
    ST_FETCH,
    ST_CALC,
    ST_LOG_INIT,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_HZ_D,
    ST_PROD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LIN_FIN,
    ST_EXP_INIT,
    ST_EXP_MUL,
    ST_EXP_UPD,
    ST_EXP_FIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quo;
    logic             rem_nz;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/scic_if.sv
`default_nettype none
interface scic_item_if import scic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [AIDX_W-1:0]   anchor_index;
  logic [TIME_W-1:0]   anchor_time;
  logic [SURV_W-1:0]   anchor_survival;
  logic [TIME_W-1:0]   query_time;

  modport source (output valid, kind, anchor_index, anchor_time, anchor_survival, query_time,
                  input ready);
  modport sink   (input valid, kind, anchor_index, anchor_time, anchor_survival, query_time,
                  output ready);
endinterface

interface scic_result_if import scic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SURV_W-1:0]   survival_value;
  logic [REGION_W-1:0] region;

  modport source (output valid, survival_value, region, input ready);
  modport sink   (input valid, survival_value, region, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/scic_mul.sv
`default_nettype none
module scic_mul import scic_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
`default_nettype wire

FILE: rtl/core/scic_div.sv
`default_nettype none
module scic_div import scic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     qn;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       rsh;
  logic [DEN_W:0]       rdiff;
  logic                 ge;

  // restoring step: one quotient bit per cycle, shifted into qn
  always_comb begin
    rsh   = {rem, qn[NUM_W-1]};
    rdiff = rsh - {1'b0, den};
    ge    = (rsh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      qn  <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      qn  <= {qn[NUM_W-2:0], ge};
      rem <= ge ? rdiff[DEN_W-1:0] : rsh[DEN_W-1:0];
    end
  end

  assign rsp.busy   = busy;
  assign rsp.quo    = qn;
  assign rsp.rem_nz = |rem;

endmodule
`default_nettype wire

FILE: rtl/core/survival_curve_interpolator.sv
`default_nettype none
// Survival curve interpolator. Anchors (time Q16.16, survival Q1.16) are loaded one per beat
// with kind = load (no result); survival above 1.0 is saturated on load. A query
// beat gives one result: time zero answers 1.0, a time equal to an anchor answers that
// anchor, otherwise the enclosing interval (with an implicit anchor at time 0, survival 1.0)
// is held, interpolated linearly or geometrically, per the method register, and the last
// interval is extrapolated past the final anchor. Results are clamped to 0..1.0. The block
// handles one query at a time: a linear scan of the anchor memory reads, then compares,
// each anchor visited; constant density adds one multiply, a bit-serial divide, a check
// that it has finished and a step to apply the quotient, and constant hazard adds two
// 16-step log2 passes and a 16-step exp2 on the shared multiplier, plus the divide. A
// finished result sits in an output register, so anchor loads and the next query are
// taken while it waits. Registers: 0 method, 4 anchor count (0 acts as 1, above 64 as
// 64). Method 3 behaves as constant survival.
module survival_curve_interpolator import scic_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  scic_item_if.sink         item,
  scic_result_if.source     result
);

  // ---------------------------------------------------------------- config regs
  logic [METHOD_W-1:0] method_r;
  logic [CNT_W-1:0]    count_r;
  logic                cfg_wr;
  reg_idx_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      method_r <= METHOD_W'(MTH_SURV);
      count_r  <= CNT_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_METHOD: method_r <= pwdata[METHOD_W-1:0];
        REG_COUNT:  count_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_METHOD: prdata = APB_DW'(method_r);
      REG_COUNT:  prdata = APB_DW'(count_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  state_t state, state_next;

  logic [TIME_W-1:0]    t_q;
  method_t              m_q;
  logic [CNT_W-1:0]     b_q;
  logic [CNT_W-1:0]     k_q;
  logic [AIDX_W-1:0]    j_q;
  logic                 jv_q;       // some anchor lies at or before t
  logic                 eq_q;       // that anchor's time equals t
  logic [TIME_W-1:0]    tj_q;
  logic [SURV_W-1:0]    sj_q;
  logic [TIME_W-1:0]    tl_q, tr_q;
  logic [SURV_W-1:0]    sl_q, sr_q;
  logic                 fetch_left_q;
  region_t              region_q;
  logic [SURV_W-1:0]    res_val_q;
  logic [TIME_W-1:0]    dt_q;
  logic [DEN_W-1:0]     delta_q;
  logic [MUL_B_W-1:0]   ds_q;
  logic                 sub_q;      // subtract quotient (negative slope)
  logic [SURV_W-1:0]    base_q;
  logic                 hz_q;
  logic                 second_q;
  logic [SURV_W-1:0]    lm_q;
  logic [LOG_W-1:0]     lr_q, la_q, lb_q;
  logic [EXP_INT_W-1:0] li_q, ei_q;
  logic [SQ_W-1:0]      p_q;
  logic [FRAC_W-1:0]    efrac_q;
  logic [EXP_INT_W-1:0] eint_q;

  // ---------------------------------------------------------------- anchor memory
  logic [TIME_W-1:0] times_mem [MAX_ANCHORS];
  logic [SURV_W-1:0] vals_mem  [MAX_ANCHORS];
  logic [TIME_W-1:0] times_q;
  logic [SURV_W-1:0] vals_q;
  logic [AIDX_W-1:0] rd_addr;
  logic              item_acc;
  logic              load_acc;
  logic              query_acc;

  assign item.ready = (state == ST_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign load_acc   = item_acc && (kind_t'(item.kind) == KIND_LOAD);
  assign query_acc  = item_acc && (kind_t'(item.kind) == KIND_QUERY);

  always_ff @(posedge clk) begin
    if (load_acc) begin
      times_mem[item.anchor_index] <= item.anchor_time;
      vals_mem[item.anchor_index]  <= (item.anchor_survival > ONE_Q16) ? ONE_Q16
                                                                       : item.anchor_survival;
    end
    times_q <= times_mem[rd_addr];
    vals_q  <= vals_mem[rd_addr];
  end

  // ---------------------------------------------------------------- shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [SQ_W-1:0]    prod_hi;
  div_req_t           dreq;
  div_rsp_t           drsp;

  scic_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  scic_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Q1.16 x Q1.16 -> drop 16 fraction bits
  assign prod_hi = prod[2*FRAC_W+1:FRAC_W];

  assign dreq.start = (state == ST_DIV_START);
  assign dreq.num   = prod;
  assign dreq.den   = delta_q;

  always_comb begin
    unique case (state)
      ST_LOG_MUL: begin
        mul_a = MUL_A_W'(lm_q);
        mul_b = MUL_B_W'(lm_q);
      end
      ST_EXP_MUL: begin
        mul_a = MUL_A_W'(p_q);
        // a clear fraction bit multiplies by 1.0, leaving p unchanged
        mul_b = efrac_q[EXP_INT_W'(FRAC_W-1) - ei_q] ? MUL_B_W'(EXP_STEPS[ei_q])
                                                     : MUL_B_W'(ONE_Q16);
      end
      default: begin
        mul_a = dt_q;
        mul_b = ds_q;
      end
    endcase
  end

  // ---------------------------------------------------------------- helper logic
  logic             scan_ge, scan_last, is_exact, is_ext;
  calc_path_t       calc_path;
  logic [SURV_W-1:0] calc_val;
  logic [SURV_W-1:0] lg_x;
  logic [4:0]       lg_n;
  logic [SQ_W-1:0]  mm;
  logic [LOG_W-1:0] lr_upd;
  logic [LOG_W-1:0] lbase;
  logic [E_W-1:0]   e_sum;
  logic             e_neg, e_big;
  logic             out_free;

  assign scan_ge   = (t_q >= times_q);
  assign scan_last = ((k_q + CNT_W'(1)) == b_q);
  assign is_exact  = jv_q && eq_q;
  assign is_ext    = jv_q && ((CNT_W'(j_q) + CNT_W'(1)) == b_q);
  assign out_free  = !result.valid || result.ready;

  always_comb begin
    calc_path = CP_VALUE;
    calc_val  = sl_q;
    if (region_q == RG_EXTRAP) begin
      calc_val = sr_q;
      if (sr_q == '0) begin
        calc_val = '0;
      end else if (m_q == MTH_SURV || tr_q <= tl_q || sl_q == sr_q) begin
        calc_val = sr_q;
      end else if (m_q == MTH_DENS) begin
        if (sl_q < sr_q) begin
          calc_val = '0;
        end else begin
          calc_path = CP_LIN;
        end
      end else if (sl_q == '0) begin
        calc_val = ONE_Q16;
      end else begin
        calc_path = CP_HAZ;
      end
    end else begin
      if (m_q == MTH_SURV || sl_q == sr_q) begin
        calc_val = sl_q;
      end else if (m_q == MTH_DENS) begin
        calc_path = CP_LIN;
      end else if (sl_q == '0 || sr_q == '0) begin
        calc_val = '0;
      end else begin
        calc_path = CP_HAZ;
      end
    end
  end

  // log2 integer part: leading one of the survival word
  assign lg_x = second_q ? sr_q : sl_q;
  always_comb begin
    lg_n = '0;
    for (int i = 0; i < SURV_W; i++) begin
      if (lg_x[i]) begin
        lg_n = 5'(i);
      end
    end
  end

  assign mm     = prod_hi;
  assign lr_upd = mm[SQ_W-1] ? (lr_q | (LOG_W'(1) << li_q)) : lr_q;

  // exponent = log2(base) +/- floor quotient; negative side rounds away from zero
  assign lbase = (region_q == RG_EXTRAP) ? lb_q : la_q;
  always_comb begin
    if (sub_q) begin
      e_sum = E_W'(lbase) + ~E_W'(drsp.quo) + E_W'(!drsp.rem_nz);
    end else begin
      e_sum = E_W'(lbase) + E_W'(drsp.quo);
    end
    e_neg = e_sum[E_W-1];
    e_big = !e_neg && (|e_sum[E_W-2:FRAC_W+EXP_INT_W]);
  end

  always_comb begin
    unique case (state)
      ST_ROUTE: begin
        if (is_ext) begin
          rd_addr = AIDX_W'(b_q - CNT_W'(2));
        end else if (jv_q) begin
          rd_addr = j_q + AIDX_W'(1);
        end else begin
          rd_addr = '0;
        end
      end
      default: rd_addr = k_q[AIDX_W-1:0];
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_acc) begin
          state_next = (item.query_time == '0) ? ST_FIN : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = (scan_ge && !scan_last) ? ST_SCAN_RD : ST_ROUTE;
      ST_ROUTE: begin
        if (is_exact) begin
          state_next = ST_FIN;
        end else if (is_ext && b_q == CNT_W'(1)) begin
          state_next = ST_CALC;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_CALC;
      ST_CALC: begin
        unique case (calc_path)
          CP_LIN:  state_next = ST_PROD;
          CP_HAZ:  state_next = ST_LOG_INIT;
          default: state_next = ST_FIN;
        endcase
      end
      ST_LOG_INIT: state_next = ST_LOG_MUL;
      ST_LOG_MUL:  state_next = ST_LOG_UPD;
      ST_LOG_UPD: begin
        if (li_q != '0) begin
          state_next = ST_LOG_MUL;
        end else begin
          state_next = second_q ? ST_HZ_D : ST_LOG_INIT;
        end
      end
      ST_HZ_D:      state_next = ST_PROD;
      ST_PROD:      state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!drsp.busy) begin
          state_next = hz_q ? ST_EXP_INIT : ST_LIN_FIN;
        end
      end
      ST_LIN_FIN:  state_next = ST_FIN;
      ST_EXP_INIT: state_next = (e_neg || e_big) ? ST_FIN : ST_EXP_MUL;
      ST_EXP_MUL:  state_next = ST_EXP_UPD;
      ST_EXP_UPD:  state_next = (ei_q == EXP_INT_W'(FRAC_W-1)) ? ST_EXP_FIN : ST_EXP_MUL;
      ST_EXP_FIN:  state_next = ST_FIN;
      ST_FIN:      state_next = out_free ? ST_IDLE : ST_FIN;
      default:     state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (query_acc) begin
          t_q       <= item.query_time;
          k_q       <= '0;
          jv_q      <= 1'b0;
          eq_q      <= 1'b0;
          region_q  <= RG_ZERO;
          res_val_q <= ONE_Q16;
          unique case (method_t'(method_r))
            MTH_DENS: m_q <= MTH_DENS;
            MTH_HAZ:  m_q <= MTH_HAZ;
            default:  m_q <= MTH_SURV;
          endcase
          if (count_r == '0) begin
            b_q <= CNT_W'(1);
          end else if (count_r > CNT_W'(MAX_ANCHORS)) begin
            b_q <= CNT_W'(MAX_ANCHORS);
          end else begin
            b_q <= count_r;
          end
        end
      end
      ST_SCAN_CMP: begin
        if (scan_ge) begin
          j_q  <= k_q[AIDX_W-1:0];
          jv_q <= 1'b1;
          eq_q <= (t_q == times_q);
          tj_q <= times_q;
          sj_q <= vals_q;
          k_q  <= k_q + CNT_W'(1);
        end
      end
      ST_ROUTE: begin
        if (is_exact) begin
          region_q  <= RG_EXACT;
          res_val_q <= sj_q;
        end else if (is_ext) begin
          region_q     <= RG_EXTRAP;
          tr_q         <= tj_q;
          sr_q         <= sj_q;
          tl_q         <= '0;
          sl_q         <= ONE_Q16;
          fetch_left_q <= 1'b1;
        end else begin
          region_q     <= RG_INTERP;
          tl_q         <= jv_q ? tj_q : '0;
          sl_q         <= jv_q ? sj_q : ONE_Q16;
          fetch_left_q <= 1'b0;
        end
      end
      ST_FETCH: begin
        if (fetch_left_q) begin
          tl_q <= times_q;
          sl_q <= vals_q;
        end else begin
          tr_q <= times_q;
          sr_q <= vals_q;
        end
      end
      ST_CALC: begin
        res_val_q <= calc_val;
        hz_q      <= (calc_path == CP_HAZ);
        second_q  <= 1'b0;
        delta_q   <= tr_q - tl_q;
        if (region_q == RG_EXTRAP) begin
          dt_q   <= t_q - tr_q;
          ds_q   <= MUL_B_W'(sl_q - sr_q);
          sub_q  <= 1'b1;
          base_q <= sr_q;
        end else begin
          dt_q   <= t_q - tl_q;
          ds_q   <= (sr_q > sl_q) ? MUL_B_W'(sr_q - sl_q) : MUL_B_W'(sl_q - sr_q);
          sub_q  <= (sl_q > sr_q);
          base_q <= sl_q;
        end
      end
      ST_LOG_INIT: begin
        lm_q <= SURV_W'(lg_x << (5'(FRAC_W) - lg_n));
        lr_q <= LOG_W'(lg_n) << FRAC_W;
        li_q <= EXP_INT_W'(FRAC_W-1);
      end
      ST_LOG_UPD: begin
        lm_q <= mm[SQ_W-1] ? mm[SQ_W-1:1] : mm[SURV_W-1:0];
        lr_q <= lr_upd;
        li_q <= li_q - EXP_INT_W'(1);
        if (li_q == '0) begin
          if (second_q) begin
            lb_q <= lr_upd;
          end else begin
            la_q     <= lr_upd;
            second_q <= 1'b1;
          end
        end
      end
      ST_HZ_D: begin
        sub_q <= (lb_q < la_q);
        ds_q  <= (lb_q < la_q) ? (la_q - lb_q) : (lb_q - la_q);
      end
      ST_LIN_FIN: begin
        if (sub_q) begin
          res_val_q <= (drsp.quo >= NUM_W'(base_q)) ? '0
                                                    : base_q - drsp.quo[SURV_W-1:0];
        end else begin
          res_val_q <= (drsp.quo > NUM_W'(ONE_Q16 - base_q)) ? ONE_Q16
                                                             : base_q + drsp.quo[SURV_W-1:0];
        end
      end
      ST_EXP_INIT: begin
        if (e_neg) begin
          res_val_q <= '0;
        end else if (e_big) begin
          res_val_q <= ONE_Q16;
        end
        efrac_q <= e_sum[FRAC_W-1:0];
        eint_q  <= e_sum[FRAC_W+EXP_INT_W-1:FRAC_W];
        p_q     <= SQ_W'(ONE_Q16);
        ei_q    <= '0;
      end
      ST_EXP_UPD: begin
        p_q  <= prod_hi;
        ei_q <= ei_q + EXP_INT_W'(1);
      end
      ST_EXP_FIN: begin
        res_val_q <= SURV_W'(p_q >> (5'(FRAC_W) - 5'(eint_q)));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result.survival_value <= res_val_q;
      result.region         <= region_q;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/scic_checker.sv
`default_nettype none
module scic_checker import scic_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [APB_AW-1:0]   paddr,
  input logic [APB_DW-1:0]   pwdata,
  input logic [APB_DW-1:0]   prdata,
  input logic                res_valid,
  input logic                res_ready,
  input logic [SURV_W-1:0]   survival_value,
  input logic [REGION_W-1:0] region
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(survival_value) && $stable(region))
    else $error("result payload changed while stalled");

  a_time_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && region == RG_ZERO |-> survival_value == ONE_Q16)
    else $error("time-zero result is not one");

  a_method_rdbk: assert property (@(posedge clk) disable iff (rst)
    !rst && psel && penable && pwrite && paddr[REG_SEL_BIT] == REG_METHOD |=>
      (!psel || pwrite || paddr[REG_SEL_BIT] != REG_METHOD ||
       prdata[METHOD_W-1:0] == $past(pwdata[METHOD_W-1:0])))
    else $error("method register read-back mismatch");

endmodule

bind survival_curve_interpolator scic_checker u_scic_checker (
  .clk            (clk),
  .rst            (rst),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .survival_value (result.survival_value),
  .region         (result.region)
);
`default_nettype wire
